[rtl/core/lrpp_pkg.sv]
// shared types and constants for the led row packet parser
package lrpp_pkg;

  // frame types taken from bytes 12 and 13
  localparam logic [15:0] TYPE_PIXELS = 16'h5500;
  localparam logic [15:0] TYPE_COMMIT = 16'h0107;

  // byte positions inside a frame
  localparam int unsigned POS_TYPE_HI = 12;
  localparam int unsigned POS_TYPE_LO = 13;
  localparam int unsigned POS_ROW     = 14;
  localparam int unsigned POS_COUNT   = 18;
  localparam int unsigned POS_BLUE0   = 21;

  localparam int unsigned CfgW    = 9;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned IdxW    = 9;
  localparam logic [IdxW-1:0] IDX_SAT = 9'd256;

  localparam logic [CfgW-1:0] PANEL_ROWS_RESET    = 9'd64;
  localparam logic [CfgW-1:0] PANEL_COLUMNS_RESET = 9'd128;

  typedef enum logic {
    CFG_PANEL_ROWS    = 1'b0,
    CFG_PANEL_COLUMNS = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    KIND_PIXEL_WRITE  = 1'b0,
    KIND_FRAME_COMMIT = 1'b1
  } out_kind_e;

  typedef enum logic [1:0] {
    PH_BLUE  = 2'd0,
    PH_GREEN = 2'd1,
    PH_RED   = 2'd2
  } color_phase_e;

endpackage

[rtl/core/led_row_packet_parser.sv]
// top level of the led row packet parser: byte stream in, pixel writes and commits out
//
// Takes one frame byte per cycle while the input is not stalled and gives at most
// one result per byte. An accepted byte is held in the input register and decoded
// against the frame state, and its result is then written into the result register,
// from which it is offered until it is taken.
// The input side stalls only while a byte that makes a result waits behind a
// result that is not yet taken. Pixel bytes are counted by a position counter
// that stops at MAX_FRAME_BYTES-1 and a blue/green/red phase counter with a pixel
// index, so no division is needed. The panel_rows and panel_columns registers are
// sampled at byte 18 of each frame and may be written whenever the block is idle.
module led_row_packet_parser
  import lrpp_pkg::*;
#(
  parameter int unsigned MAX_FRAME_BYTES = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte input
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  frame_byte_i,
  input  logic        frame_last_i,
  // result output
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        out_kind_o,
  output logic [7:0]  pixel_column_o,
  output logic [7:0]  pixel_row_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  // register writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [8:0]  cfg_data_i
);

  localparam int unsigned PosW = $clog2(MAX_FRAME_BYTES);
  localparam logic [PosW-1:0] PosMax = PosW'(MAX_FRAME_BYTES - 1);

  // configuration
  logic [CfgW-1:0] rows_q, cols_q;

  // input register
  logic              s1_valid_q;
  logic [7:0]        s1_byte_q;
  logic              s1_last_q;

  // frame state
  logic [PosW-1:0]   pos_q, pos_d;
  logic [15:0]       type_q, type_d;
  logic [7:0]        row_q, row_d;
  logic [CfgW-1:0]   limit_q, limit_d;
  logic [7:0]        blue_q, blue_d, green_q, green_d;
  color_phase_e      phase_q, phase_d;
  logic [IdxW-1:0]   idx_q, idx_d;

  // result register
  logic              out_valid_q;
  out_kind_e         kind_q, kind_d;
  logic [7:0]        col_q, col_d, orow_q, orow_d;
  logic [7:0]        red_q, red_d, ogreen_q, ogreen_d, oblue_q, oblue_d;

  logic out_ready, emit, emit_pixel, emit_commit, s1_adv;
  logic [15:0]     type_now;
  logic [CfgW-1:0] lim;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= PANEL_ROWS_RESET;
      cols_q <= PANEL_COLUMNS_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_PANEL_ROWS:    rows_q <= cfg_data_i;
        CFG_PANEL_COLUMNS: cols_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign s1_adv     = s1_valid_q && (!emit || out_ready);
  assign in_stall_o = s1_valid_q && !s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o) begin
      s1_byte_q <= frame_byte_i;
      s1_last_q <= frame_last_i;
    end
  end

  // decode of the held byte against the frame state
  always_comb begin
    pos_d    = pos_q;
    type_d   = type_q;
    row_d    = row_q;
    limit_d  = limit_q;
    blue_d   = blue_q;
    green_d  = green_q;
    phase_d  = phase_q;
    idx_d    = idx_q;
    emit_pixel = 1'b0;
    lim = ({1'b0, s1_byte_q} < cols_q) ? {1'b0, s1_byte_q} : cols_q;

    if (pos_q == PosW'(POS_TYPE_HI)) begin
      type_d = {s1_byte_q, 8'h00};
    end else if (pos_q == PosW'(POS_TYPE_LO)) begin
      type_d = {type_q[15:8], s1_byte_q};
    end else if (pos_q == PosW'(POS_ROW)) begin
      row_d = s1_byte_q;
    end else if (pos_q == PosW'(POS_COUNT)) begin
      limit_d = ({1'b0, row_q} < rows_q) ? lim : '0;
    end else if (pos_q >= PosW'(POS_BLUE0) && type_q == TYPE_PIXELS) begin
      case (phase_q)
        PH_BLUE:  blue_d  = s1_byte_q;
        PH_GREEN: green_d = s1_byte_q;
        default:  emit_pixel = (idx_q < limit_q);
      endcase
    end
    type_now = type_d;

    if (s1_last_q) begin
      pos_d   = '0;
      type_d  = '0;
      row_d   = '0;
      limit_d = '0;
      blue_d  = '0;
      green_d = '0;
      phase_d = PH_BLUE;
      idx_d   = '0;
    end else if (pos_q < PosMax) begin
      pos_d = pos_q + 1'b1;
      // phase and pixel index only move while the position does
      if (pos_q >= PosW'(POS_BLUE0)) begin
        case (phase_q)
          PH_BLUE:  phase_d = PH_GREEN;
          PH_GREEN: phase_d = PH_RED;
          default: begin
            phase_d = PH_BLUE;
            idx_d   = (idx_q == IDX_SAT) ? idx_q : idx_q + 1'b1;
          end
        endcase
      end
    end
  end

  assign emit_commit = s1_last_q && !emit_pixel && pos_q >= PosW'(POS_TYPE_LO)
                       && type_now == TYPE_COMMIT;
  assign emit = emit_pixel || emit_commit;

  always_comb begin
    kind_d   = KIND_PIXEL_WRITE;
    col_d    = idx_q[7:0];
    orow_d   = row_q;
    red_d    = s1_byte_q;
    ogreen_d = green_q;
    oblue_d  = blue_q;
    if (!emit_pixel) begin
      kind_d   = KIND_FRAME_COMMIT;
      col_d    = '0;
      orow_d   = '0;
      red_d    = '0;
      ogreen_d = '0;
      oblue_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= '0;
      type_q  <= '0;
      row_q   <= '0;
      limit_q <= '0;
      blue_q  <= '0;
      green_q <= '0;
      phase_q <= PH_BLUE;
      idx_q   <= '0;
    end else if (s1_adv) begin
      pos_q   <= pos_d;
      type_q  <= type_d;
      row_q   <= row_d;
      limit_q <= limit_d;
      blue_q  <= blue_d;
      green_q <= green_d;
      phase_q <= phase_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (s1_adv && emit) begin
        out_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && emit) begin
      kind_q   <= kind_d;
      col_q    <= col_d;
      orow_q   <= orow_d;
      red_q    <= red_d;
      ogreen_q <= ogreen_d;
      oblue_q  <= oblue_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_kind_o     = kind_q;
  assign pixel_column_o = col_q;
  assign pixel_row_o    = orow_q;
  assign red_o          = red_q;
  assign green_o        = ogreen_q;
  assign blue_o         = oblue_q;

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosMax)
    else $error("byte position past saturation point");

  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idx_q <= IDX_SAT)
    else $error("pixel index past saturation");

  a_commit_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && kind_q == KIND_FRAME_COMMIT |->
      col_q == '0 && orow_q == '0 && red_q == '0 && ogreen_q == '0 && oblue_q == '0)
    else $error("frame commit carries nonzero pixel fields");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && s1_last_q |=> pos_q == '0 && type_q == '0 && limit_q == '0 && idx_q == '0)
    else $error("frame state not cleared after last beat");

  a_one_result_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(emit_pixel && emit_commit))
    else $error("pixel write and commit from the same beat");

endmodule

[dv/tb_led_row_packet_parser.sv]
// testbench for led_row_packet_parser: framed byte stimulus checked against an in-bench predictor
`timescale 1ns / 1ps

module tb_led_row_packet_parser;
  import lrpp_pkg::*;

  localparam int unsigned FRAME_BYTES_MAX = 2048;
  localparam int unsigned LATENCY_SLACK   = 8;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned PHASE_BYTES     = 110;
  localparam int unsigned MAX_REPORTS     = 64;
  localparam longint      TIMEOUT_NS      = 12_000_000;
  localparam logic [11:0] NO_BREAK        = 12'hFFF;
  localparam logic [8:0]  RANDOM_CFG      = 9'h1FF;

  typedef enum logic [1:0] {
    FILL_RANDOM,
    FILL_ONES,
    FILL_ZEROS
  } fill_e;

  // how the results of a frame are worked out
  typedef enum logic [1:0] {
    CHECK_MODEL,
    CHECK_NONE,
    CHECK_COMMIT
  } check_e;

  typedef struct packed {
    logic [15:0] ftype;
    logic [7:0]  row;
    logic [7:0]  count;
    logic [11:0] len;
    fill_e       fill;
    logic [11:0] break_at;
    logic [8:0]  break_rows;
    logic [8:0]  break_cols;
    check_e      check;
  } frame_desc_t;

  typedef struct packed {
    out_kind_e  kind;
    logic [7:0] column;
    logic [7:0] row;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_result_t;

  localparam frame_desc_t DIRECTED_FRAMES [18] = '{
    '{TYPE_COMMIT, 8'd0, 8'd0, 12'd14, FILL_RANDOM, NO_BREAK, 9'd0, 9'd0, CHECK_COMMIT},
    '{TYPE_COMMIT, 8'd0, 8'd0, 12'd13, FILL_RANDOM, NO_BREAK, 9'd0, 9'd0, CHECK_NONE},
    '{TYPE_PIXELS, 8'd0, 8'd1, 12'd1, FILL_RANDOM, NO_BREAK, 9'd0, 9'd0, CHECK_NONE},
    '{TYPE_PIXELS, 8'd0, 8'd1, 12'd13, FILL_RANDOM, NO_BREAK, 9'd0, 9'd0, CHECK_NONE},
    '{16'h5501, 8'd0, 8'd4, 12'd40, FILL_RANDOM, NO_BREAK, 9'd0, 9'd0, CHECK_NONE},
    '{16'h0106, 8'd0, 8'd4, 12'd20, FILL_RANDOM, NO_BREAK, 9'd0, 9'd0, CHECK_NONE},
    '{TYPE_PIXELS, 8'd0, 8'd1, 12'd24, FILL_ONES, NO_BREAK, 9'd0, 9'd0, CHECK_MODEL},
    '{TYPE_PIXELS, 8'd63, 8'd4, 12'd33, FILL_ZEROS, NO_BREAK, 9'd0, 9'd0, CHECK_MODEL},
    '{TYPE_PIXELS, 8'd64, 8'd4, 12'd33, FILL_RANDOM, NO_BREAK, 9'd0, 9'd0, CHECK_NONE},
    '{TYPE_PIXELS, 8'd255, 8'd3, 12'd30, FILL_ONES, NO_BREAK, 9'd0, 9'd0, CHECK_NONE},
    '{TYPE_PIXELS, 8'd5, 8'd0, 12'd40, FILL_RANDOM, NO_BREAK, 9'd0, 9'd0, CHECK_NONE},
    '{TYPE_PIXELS, 8'd1, 8'd255, 12'd40, FILL_RANDOM, 12'd18, 9'd64, 9'd4, CHECK_MODEL},
    '{TYPE_PIXELS, 8'd2, 8'd6, 12'd32, FILL_RANDOM, NO_BREAK, 9'd0, 9'd0, CHECK_MODEL},
    '{TYPE_PIXELS, 8'd10, 8'd5, 12'd36, FILL_RANDOM, 12'd19, 9'd0, 9'd0, CHECK_MODEL},
    '{TYPE_PIXELS, 8'd10, 8'd5, 12'd36, FILL_RANDOM, NO_BREAK, 9'd0, 9'd0, CHECK_NONE},
    '{TYPE_PIXELS, 8'd255, 8'd255, 12'd90, FILL_RANDOM, 12'd18, 9'd256, 9'd256,
      CHECK_MODEL},
    '{TYPE_PIXELS, 8'd7, 8'd2, 12'd27, FILL_ONES, NO_BREAK, 9'd0, 9'd0, CHECK_MODEL},
    '{TYPE_COMMIT, 8'd0, 8'd0, 12'd22, FILL_RANDOM, NO_BREAK, 9'd0, 9'd0, CHECK_COMMIT}
  };

  // panel settings per random phase, RANDOM_CFG picks a fresh value
  localparam logic [8:0] PHASE_ROWS [8] = '{9'd64, 9'd256, 9'd0, 9'd256, 9'd1,
                                            RANDOM_CFG, RANDOM_CFG, 9'd256};
  localparam logic [8:0] PHASE_COLS [8] = '{9'd128, 9'd256, 9'd12, 9'd0, 9'd1,
                                            RANDOM_CFG, RANDOM_CFG, 9'd1};

  logic       clk_i        = 1'b0;
  logic       rst_ni       = 1'b0;
  logic       in_valid_i   = 1'b0;
  logic       in_stall_o;
  logic [7:0] frame_byte_i = 8'h00;
  logic       frame_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i  = 1'b0;
  logic       out_kind_o;
  logic [7:0] pixel_column_o;
  logic [7:0] pixel_row_o;
  logic [7:0] red_o;
  logic [7:0] green_o;
  logic [7:0] blue_o;
  logic       cfg_valid_i  = 1'b0;
  logic       cfg_ready_o;
  cfg_reg_e   cfg_index_i  = CFG_PANEL_ROWS;
  logic [8:0] cfg_data_i   = 9'd0;

  // predictor state
  logic [10:0] byte_pos_q   = '0;
  logic [15:0] frame_type_q = '0;
  logic [7:0]  row_q        = '0;
  logic [8:0]  limit_q      = '0;
  logic [7:0]  blue_q       = '0;
  logic [7:0]  green_q      = '0;
  logic [8:0]  rows_cfg     = PANEL_ROWS_RESET;
  logic [8:0]  cols_cfg     = PANEL_COLUMNS_RESET;

  pixel_result_t pending_results [$];
  int unsigned   mismatch_count    = 0;
  int unsigned   bytes_sent        = 0;
  int unsigned   send_idle_pct     = 0;
  int unsigned   recv_stall_pct    = 0;
  int unsigned   hold_off_requests = 0;

  led_row_packet_parser #(
    .MAX_FRAME_BYTES(FRAME_BYTES_MAX)
  ) i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .frame_byte_i  (frame_byte_i),
    .frame_last_i  (frame_last_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_kind_o    (out_kind_o),
    .pixel_column_o(pixel_column_o),
    .pixel_row_o   (pixel_row_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(string what);
    if (mismatch_count < MAX_REPORTS) begin
      $display("%0t: %s", $time, what);
    end
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s: got %0h, want %0h", name, got, want));
    end
  endtask

  // advance the frame state by one accepted byte
  task automatic decode_byte(input logic [7:0] b, input logic last,
                             output bit emit, output pixel_result_t res);
    int         off;
    logic [8:0] lim;
    emit = 1'b0;
    res  = '0;
    off  = int'(byte_pos_q) - int'(POS_BLUE0);
    if (byte_pos_q == POS_TYPE_HI) begin
      frame_type_q = {b, 8'h00};
    end else if (byte_pos_q == POS_TYPE_LO) begin
      frame_type_q[7:0] = b;
    end else if (byte_pos_q == POS_ROW) begin
      row_q = b;
    end else if (byte_pos_q == POS_COUNT) begin
      lim     = ({1'b0, b} < cols_cfg) ? {1'b0, b} : cols_cfg;
      limit_q = ({1'b0, row_q} < rows_cfg) ? lim : '0;
    end else if (off >= 0 && frame_type_q == TYPE_PIXELS) begin
      case (color_phase_e'(off % 3))
        PH_BLUE: begin
          blue_q = b;
        end
        PH_GREEN: begin
          green_q = b;
        end
        default: begin
          if (off / 3 < int'(limit_q)) begin
            emit       = 1'b1;
            res.kind   = KIND_PIXEL_WRITE;
            res.column = 8'(off / 3);
            res.row    = row_q;
            res.red    = b;
            res.green  = green_q;
            res.blue   = blue_q;
          end
        end
      endcase
    end
    if (last) begin
      if (!emit && byte_pos_q >= POS_TYPE_LO && frame_type_q == TYPE_COMMIT) begin
        emit     = 1'b1;
        res      = '0;
        res.kind = KIND_FRAME_COMMIT;
      end
      byte_pos_q   = '0;
      frame_type_q = '0;
      row_q        = '0;
      limit_q      = '0;
      blue_q       = '0;
      green_q      = '0;
    end else if (byte_pos_q < FRAME_BYTES_MAX - 1) begin
      byte_pos_q++;
    end
  endtask

  function automatic logic [7:0] frame_byte_at(frame_desc_t d, int unsigned p);
    if (p == POS_TYPE_HI) return d.ftype[15:8];
    if (p == POS_TYPE_LO) return d.ftype[7:0];
    if (p == POS_ROW) return d.row;
    if (p == POS_COUNT) return d.count;
    if (p >= POS_BLUE0 && d.fill == FILL_ONES) return 8'hFF;
    if (p >= POS_BLUE0 && d.fill == FILL_ZEROS) return 8'h00;
    return 8'($urandom);
  endfunction

  function automatic frame_desc_t random_frame();
    frame_desc_t d;
    int unsigned pick;
    int unsigned c;
    int unsigned full;
    d = '{16'($urandom), 8'($urandom), 8'($urandom), 12'd1, FILL_RANDOM, NO_BREAK,
          9'd0, 9'd0, CHECK_MODEL};
    pick = $urandom_range(99);
    if (pick < 60) begin
      d.ftype = TYPE_PIXELS;
      c = $urandom_range(2);
      if (c == 1 && rows_cfg != 0) begin
        d.row = 8'($urandom_range(0, rows_cfg - 1));
      end else if (c == 2 && rows_cfg != 0) begin
        d.row = (rows_cfg >= 256) ? 8'd255 : 8'(rows_cfg - 1 + $urandom_range(0, 1));
      end
      c = $urandom_range(9);
      if (c < 7 || (c < 9 && cols_cfg > 16)) begin
        d.count = 8'($urandom_range(0, 8));
      end else if (c < 9) begin
        d.count = 8'(((cols_cfg == 0) ? 0 : cols_cfg - 1) + $urandom_range(0, 2));
      end
      full = POS_BLUE0 + 3 * d.count;
      if (c == 9) begin
        // any count, cut short so the frame stays cheap
        d.len = 12'($urandom_range(1, POS_BLUE0 + 30));
      end else if ($urandom_range(9) == 0) begin
        d.len = 12'($urandom_range(1, full));
      end else begin
        d.len = 12'(full + $urandom_range(0, 3));
      end
    end else if (pick < 75) begin
      d.ftype = TYPE_COMMIT;
      d.len   = 12'($urandom_range(13, 30));
    end else if (pick < 85) begin
      // near misses of both frame types, or a random type
      case ($urandom_range(2))
        0: d.ftype = TYPE_PIXELS ^ (16'h1 << $urandom_range(15));
        1: d.ftype = TYPE_COMMIT ^ (16'h1 << $urandom_range(15));
        default: d.ftype = 16'($urandom);
      endcase
      d.len = 12'($urandom_range(14, 40));
    end else if (pick < 93) begin
      d.ftype = $urandom_range(1) ? TYPE_PIXELS : TYPE_COMMIT;
      d.len   = 12'($urandom_range(1, 13));
    end else begin
      d.len = 12'($urandom_range(1, 40));
    end
    return d;
  endfunction

  task automatic set_idle(int unsigned mode);
    case (mode)
      0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
      1: begin send_idle_pct = 86; recv_stall_pct <= 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct <= 86; end
      default: begin send_idle_pct = 32; recv_stall_pct <= 32; end
    endcase
  endtask

  // called at a falling edge, returns at a falling edge
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (LATENCY_SLACK) @(negedge clk_i);
  endtask

  task automatic write_cfg(cfg_reg_e idx, logic [8:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_PANEL_ROWS) begin
      rows_cfg = value;
    end else begin
      cols_cfg = value;
    end
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_beat(logic [7:0] b, logic last, check_e check);
    bit            emit;
    pixel_result_t res;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    frame_last_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    decode_byte(b, last, emit, res);
    if (check == CHECK_MODEL && emit) begin
      pending_results.push_back(res);
    end else if (check == CHECK_COMMIT && last) begin
      pending_results.push_back(pixel_result_t'{KIND_FRAME_COMMIT, 8'd0, 8'd0, 8'd0,
                                                8'd0, 8'd0});
    end
    bytes_sent++;
    @(negedge clk_i);
  endtask

  task automatic drive_frame(frame_desc_t d);
    for (int p = 0; p < int'(d.len); p++) begin
      if (p == int'(d.break_at)) begin
        drain_results();
        write_cfg(CFG_PANEL_ROWS, d.break_rows);
        write_cfg(CFG_PANEL_COLUMNS, d.break_cols);
      end
      send_beat(frame_byte_at(d, p), p == int'(d.len) - 1, d.check);
    end
  endtask

  // receiver stall, with a long hold-off on request
  initial begin : out_stall_gen
    int unsigned hold_left;
    int unsigned seen;
    hold_left = 0;
    seen      = 0;
    forever begin
      @(negedge clk_i);
      if (hold_off_requests != seen) begin
        seen      = hold_off_requests;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else begin
        out_stall_i <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    pixel_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result kind %0d column %0d row %0d",
                                  out_kind_o, pixel_column_o, pixel_row_o));
      end else begin
        want = pending_results.pop_front();
        check_field("out_kind", {7'd0, out_kind_o}, {7'd0, want.kind});
        check_field("pixel_column", pixel_column_o, want.column);
        check_field("pixel_row", pixel_row_o, want.row);
        check_field("red", red_o, want.red);
        check_field("green", green_o, want.green);
        check_field("blue", blue_o, want.blue);
      end
    end
  end

  initial begin : timeout
    #TIMEOUT_NS;
    $display("led_row_packet_parser: mismatch");
    $finish;
  end

  initial begin : stimulus
    int unsigned phase_end;
    logic [8:0]  value;
    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    set_idle(3);
    foreach (DIRECTED_FRAMES[i]) begin
      drive_frame(DIRECTED_FRAMES[i]);
    end

    for (int ph = 0; ph < 8; ph++) begin
      drain_results();
      value = (PHASE_ROWS[ph] == RANDOM_CFG) ? 9'($urandom_range(0, 256)) : PHASE_ROWS[ph];
      write_cfg(CFG_PANEL_ROWS, value);
      value = (PHASE_COLS[ph] == RANDOM_CFG) ? 9'($urandom_range(1, 12)) : PHASE_COLS[ph];
      write_cfg(CFG_PANEL_COLUMNS, value);
      set_idle(ph % 4);
      if (ph == 0) begin
        // receiver holds off while a dense pixel frame keeps coming
        hold_off_requests <= hold_off_requests + 1;
        drive_frame(frame_desc_t'{TYPE_PIXELS, 8'd0, 8'd40, 12'd141, FILL_RANDOM,
                                  NO_BREAK, 9'd0, 9'd0, CHECK_MODEL});
      end
      phase_end = bytes_sent + PHASE_BYTES;
      while (bytes_sent < phase_end) begin
        drive_frame(random_frame());
      end
    end

    drain_results();
    if (mismatch_count == 0) begin
      $display("led_row_packet_parser: match");
    end else begin
      $display("led_row_packet_parser: mismatch");
    end
    $finish;
  end

endmodule

[led_row_packet_parser.f]
rtl/core/lrpp_pkg.sv
rtl/core/led_row_packet_parser.sv
dv/tb_led_row_packet_parser.sv
